### rtl/bce_pkg.sv
package bce_pkg;

   localparam int unsigned RATE_BITS = 16;
   localparam int unsigned EXP_CUTOFF = 23;
   localparam int unsigned SERIES_TERMS = 13;
   localparam int unsigned LANE_LATENCY = 3 * (SERIES_TERMS - 1) + 3;
   localparam int unsigned QUOT_BITS = 33;
   localparam int unsigned DIV_BITS_PER_STAGE = 4;
   localparam int unsigned DIV_STAGES =
      (QUOT_BITS + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;

   localparam logic [31:0] EXP_NEG_ONE = 32'd1580030169;
   localparam logic [15:0] ABSORPTION_RATE_RESET = 16'd1311;
   localparam logic [15:0] ELIMINATION_RATE_RESET = 16'd655;

   localparam logic [0:0] CSR_ABSORPTION_RATE = 1'd0;
   localparam logic [0:0] CSR_ELIMINATION_RATE = 1'd1;

   typedef logic [31:0] pow_table_type [0:EXP_CUTOFF-1];

   // Powers of exp(-1) in Q0.32, each product rounded to nearest.
   function automatic pow_table_type build_pow_table();
      pow_table_type tbl;
      logic [63:0] p;
      tbl[0] = '0;
      p = 64'(EXP_NEG_ONE);
      tbl[1] = p[31:0];
      for (int i = 2; i < EXP_CUTOFF; i++) begin
         p = (p * 64'(EXP_NEG_ONE) + 64'h8000_0000) >> 32;
         tbl[i] = p[31:0];
      end
      return tbl;
   endfunction

   localparam pow_table_type EXP_POW_TABLE = build_pow_table();

endpackage

### rtl/bce_exp_lane.sv
module bce_exp_lane
   import bce_pkg::*;
#(
   parameter int unsigned TIME_BITS = 16
) (
   input  logic                 clock,
   input  logic                 enable,
   input  logic [TIME_BITS-1:0] whole_in,
   input  logic [15:0]          frac_in,
   output logic [32:0]          exp_out
);

   localparam int unsigned STEPS = SERIES_TERMS - 1;
   localparam int unsigned SIDE_LAST = 3 * STEPS + 1;
   localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

   typedef struct packed {
      logic [15:0] frac;
      logic [31:0] pow;
      logic        cut;
      logic        whole_zero;
   } lane_side_type;

   lane_side_type side_in;
   lane_side_type side_ff [0:SIDE_LAST];

   logic [31:0] prod_ff  [0:STEPS-1];
   logic [31:0] prod2_ff [0:STEPS-1];
   logic [31:0] qe_ff    [0:STEPS-1];
   logic [32:0] r_ff     [1:STEPS];
   logic [32:0] r_last_ff;
   logic [32:0] exp_ff;

   logic [48:0] last_full;
   logic [64:0] round_full;
   logic [32:0] exp_in;

   always_comb begin
      side_in.frac = frac_in;
      side_in.cut = whole_in >= TIME_BITS'(EXP_CUTOFF);
      side_in.whole_zero = whole_in == '0;
      if (side_in.cut) begin
         side_in.pow = '0;
      end else begin
         side_in.pow = EXP_POW_TABLE[whole_in[4:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         side_ff[0] <= side_in;
         for (int i = 1; i <= SIDE_LAST; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // Horner terms of the series for exp(-f), one divisor per three stages.
   for (genvar j = 0; j < STEPS; j++) begin : g_term
      localparam int unsigned K = SERIES_TERMS - j;
      localparam logic [35:0] RECIP = 36'((64'd1 << 36) / K);
      localparam logic [35:0] KW = 36'(K);

      logic [32:0] r_cur;
      logic [48:0] mul_full;
      logic [67:0] rec_full;
      logic [35:0] back_full;
      logic [31:0] rem;
      logic [31:0] q_fix;

      if (j == 0) begin : g_first
         assign r_cur = ONE_Q32;
      end else begin : g_next
         assign r_cur = r_ff[j];
      end

      assign mul_full = 49'(side_ff[3*j].frac) * 49'(r_cur);
      assign rec_full = 68'(prod_ff[j]) * 68'(RECIP);
      assign back_full = 36'(qe_ff[j]) * KW;
      assign rem = prod2_ff[j] - back_full[31:0];
      assign q_fix = qe_ff[j] + 32'(rem >= 32'(K));

      always_ff @(posedge clock) begin
         if (enable) begin
            prod_ff[j] <= mul_full[47:16];
            qe_ff[j] <= rec_full[67:36];
            prod2_ff[j] <= prod_ff[j];
            r_ff[j+1] <= ONE_Q32 - 33'(q_fix);
         end
      end
   end

   assign last_full = 49'(side_ff[3*STEPS].frac) * 49'(r_ff[STEPS]);
   assign round_full = 65'(side_ff[SIDE_LAST].pow) * 65'(r_last_ff) + 65'h8000_0000;

   always_comb begin
      if (side_ff[SIDE_LAST].cut) begin
         exp_in = '0;
      end else if (side_ff[SIDE_LAST].whole_zero) begin
         exp_in = r_last_ff;
      end else begin
         exp_in = round_full[64:32];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         r_last_ff <= ONE_Q32 - {1'b0, last_full[47:16]};
         exp_ff <= exp_in;
      end
   end

   assign exp_out = exp_ff;

endmodule

### rtl/bateman_curve_evaluator_top.sv
// Channel   Direction  Transfer when                 Payload
// req       in         req_valid && req_ready        req_elapsed_minutes
// rsp       out        rsp_valid && rsp_ready        rsp_activity
// csr       in         csr_write_enable              csr_index, csr_write_data
//
// From transfer to result an item passes one multiply stage, 39 stages per exponential
// lane (three per series term), a difference stage, a multiply stage, nine restoring
// division stages and the output register. One item enters every cycle unless stalled.
// Reset clears all valid bits and loads the rate registers with their defaults.
// A stalled result holds the whole pipeline, so nothing is dropped or repeated.
module bateman_curve_evaluator_top
   import bce_pkg::*;
#(
   parameter int unsigned TIME_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [TIME_BITS-1:0] req_elapsed_minutes,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [15:0]          rsp_activity,
   input  logic                 csr_write_enable,
   input  logic [0:0]           csr_index,
   input  logic [15:0]          csr_write_data
);

   localparam int unsigned XW = TIME_BITS + RATE_BITS;

   logic [15:0] absorption_rate_ff;
   logic [15:0] elimination_rate_ff;

   logic          advance;
   logic          ka_greater;
   logic [15:0]   den;

   logic          s0_valid_ff;
   logic          s0_zero_ff;
   logic [XW-1:0] s0_x_ka_ff;
   logic [XW-1:0] s0_x_kel_ff;

   logic lane_valid_ff [0:LANE_LATENCY-1];
   logic lane_zero_ff  [0:LANE_LATENCY-1];
   logic [32:0] exp_ka;
   logic [32:0] exp_kel;

   logic        d_valid_ff;
   logic        d_zero_ff;
   logic [32:0] d_ff;
   logic [32:0] d_in;
   logic        d_bad;

   logic        num_valid_ff;
   logic        num_zero_ff;
   logic [48:0] num_ff;

   logic        div_valid_ff [0:DIV_STAGES-1];
   logic        div_zero_ff  [0:DIV_STAGES-1];
   logic        div_sat_ff   [0:DIV_STAGES-1];
   logic [15:0] div_rem_ff   [0:DIV_STAGES-1];
   logic [32:0] div_quot_ff  [0:DIV_STAGES-1];
   logic [32:0] div_low_ff   [0:DIV_STAGES-1];

   logic        rsp_valid_ff;
   logic [15:0] rsp_activity_ff;
   logic [33:0] round_sum;
   logic [15:0] activity_in;

   assign advance = ~rsp_valid_ff | rsp_ready;
   assign req_ready = advance;
   assign ka_greater = absorption_rate_ff > elimination_rate_ff;
   assign den = ka_greater ? absorption_rate_ff - elimination_rate_ff
                           : elimination_rate_ff - absorption_rate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         absorption_rate_ff <= ABSORPTION_RATE_RESET;
         elimination_rate_ff <= ELIMINATION_RATE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ABSORPTION_RATE: begin
               absorption_rate_ff <= csr_write_data;
            end
            CSR_ELIMINATION_RATE: begin
               elimination_rate_ff <= csr_write_data;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_zero_ff <= (req_elapsed_minutes == '0)
                       || (absorption_rate_ff == elimination_rate_ff);
         s0_x_ka_ff <= XW'(absorption_rate_ff) * XW'(req_elapsed_minutes);
         s0_x_kel_ff <= XW'(elimination_rate_ff) * XW'(req_elapsed_minutes);
      end
   end

   bce_exp_lane #(
      .TIME_BITS (TIME_BITS)
   ) u_lane_ka (
      .clock    (clock),
      .enable   (advance),
      .whole_in (s0_x_ka_ff[XW-1:RATE_BITS]),
      .frac_in  (s0_x_ka_ff[RATE_BITS-1:0]),
      .exp_out  (exp_ka)
   );

   bce_exp_lane #(
      .TIME_BITS (TIME_BITS)
   ) u_lane_kel (
      .clock    (clock),
      .enable   (advance),
      .whole_in (s0_x_kel_ff[XW-1:RATE_BITS]),
      .frac_in  (s0_x_kel_ff[RATE_BITS-1:0]),
      .exp_out  (exp_kel)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LANE_LATENCY; i++) begin
            lane_valid_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         lane_valid_ff[0] <= s0_valid_ff;
         for (int i = 1; i < LANE_LATENCY; i++) begin
            lane_valid_ff[i] <= lane_valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lane_zero_ff[0] <= s0_zero_ff;
         for (int i = 1; i < LANE_LATENCY; i++) begin
            lane_zero_ff[i] <= lane_zero_ff[i-1];
         end
      end
   end

   // A difference of the wrong sign or of zero comes from rounding and yields zero.
   always_comb begin
      if (ka_greater) begin
         d_bad = exp_kel <= exp_ka;
         d_in = exp_kel - exp_ka;
      end else begin
         d_bad = exp_ka <= exp_kel;
         d_in = exp_ka - exp_kel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
         num_valid_ff <= 1'b0;
      end else if (advance) begin
         d_valid_ff <= lane_valid_ff[LANE_LATENCY-1];
         num_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d_zero_ff <= lane_zero_ff[LANE_LATENCY-1] | d_bad;
         d_ff <= d_in;
         num_zero_ff <= d_zero_ff;
         num_ff <= 49'(absorption_rate_ff) * 49'(d_ff);
      end
   end

   // Restoring division of the scaled difference by the rate gap.
   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      logic        src_valid;
      logic        src_zero;
      logic        src_sat;
      logic [15:0] src_rem;
      logic [32:0] src_quot;
      logic [32:0] src_low;
      logic [15:0] rem_w;
      logic [32:0] quot_w;
      logic [32:0] low_w;
      logic [16:0] trial;

      if (s == 0) begin : g_head
         assign src_valid = num_valid_ff;
         assign src_zero = num_zero_ff;
         assign src_sat = num_ff[48:33] >= den;
         assign src_rem = num_ff[48:33];
         assign src_quot = '0;
         assign src_low = num_ff[32:0];
      end else begin : g_body
         assign src_valid = div_valid_ff[s-1];
         assign src_zero = div_zero_ff[s-1];
         assign src_sat = div_sat_ff[s-1];
         assign src_rem = div_rem_ff[s-1];
         assign src_quot = div_quot_ff[s-1];
         assign src_low = div_low_ff[s-1];
      end

      always_comb begin
         rem_w = src_rem;
         quot_w = src_quot;
         low_w = src_low;
         trial = '0;
         for (int b = 0; b < DIV_BITS_PER_STAGE; b++) begin
            if (s * DIV_BITS_PER_STAGE + b < QUOT_BITS) begin
               trial = {rem_w, low_w[32]};
               low_w = {low_w[31:0], 1'b0};
               if (trial >= {1'b0, den}) begin
                  trial = trial - {1'b0, den};
                  quot_w = {quot_w[31:0], 1'b1};
               end else begin
                  quot_w = {quot_w[31:0], 1'b0};
               end
               rem_w = trial[15:0];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_valid_ff[s] <= 1'b0;
         end else if (advance) begin
            div_valid_ff[s] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            div_zero_ff[s] <= src_zero;
            div_sat_ff[s] <= src_sat;
            div_rem_ff[s] <= rem_w;
            div_quot_ff[s] <= quot_w;
            div_low_ff[s] <= low_w;
         end
      end
   end

   assign round_sum = 34'(div_quot_ff[DIV_STAGES-1]) + 34'h8000;

   always_comb begin
      if (div_zero_ff[DIV_STAGES-1]) begin
         activity_in = '0;
      end else if (div_sat_ff[DIV_STAGES-1] || (round_sum[33:32] != 2'b00)) begin
         activity_in = 16'hFFFF;
      end else begin
         activity_in = round_sum[31:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= div_valid_ff[DIV_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_activity_ff <= activity_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_activity = rsp_activity_ff;

endmodule
